FILE: rtl/core/crlb_pkg.sv
package crlb_pkg;

  // Field widths of the item and register words
  localparam int TIME_W     = 32;
  localparam int SLOT_W     = 5;
  localparam int AFF_W      = 12;
  localparam int CORE_W     = 4;
  localparam int STATUS_W   = 3;
  localparam int REMOVED_W  = 24;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MARGIN_W   = 8;

  // Client weight is 10 plus foreground plus priority
  localparam int WEIGHT_W                 = 4;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BASE = 4'd10;
  localparam int WEIGHT_MAX               = 12;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BALANCE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_BALANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_MARGIN  = 3'd5;

  // Register reset values
  localparam logic [CORE_W-1:0]   CORE_COUNT_RST   = 4'd1;
  localparam logic [TIME_W-1:0]   BUSY_TIMEOUT_RST = 32'd3000;
  localparam logic [TIME_W-1:0]   DEAD_TIMEOUT_RST = 32'd60000;
  localparam logic                AUTO_BALANCE_RST = 1'b1;
  localparam logic [MARGIN_W-1:0] MOVE_FLOOR_RST   = 8'd20;
  localparam logic [MARGIN_W-1:0] MOVE_MARGIN_RST  = 8'd10;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_MOVE      = 3'd0,
    ST_NO_MOVE   = 3'd1,
    ST_BUSY      = 3'd2,
    ST_UNSETTLED = 3'd3,
    ST_DISABLED  = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    SQ_IDLE,
    SQ_PRIME,
    SQ_DEAD,
    SQ_BUSY,
    SQ_CHECK,
    SQ_SCAN,
    SQ_PICK_PRIME,
    SQ_PICK,
    SQ_DONE
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [AFF_W-1:0]  affinity;
    logic              foreground;
    logic              priority_req;
    logic [TIME_W-1:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    client_slot;
    logic [CORE_W-1:0]    target_core;
    logic [REMOVED_W-1:0] removed_slots;
  } out_item_t;

  // One slot table entry
  typedef struct packed {
    logic [AFF_W-1:0]  affinity;
    logic              foreground;
    logic              priority_req;
    logic [TIME_W-1:0] last_report;
  } slot_rec_t;

  // Sequencer commands to the load unit
  typedef struct packed {
    logic clr;
    logic add;
    logic scan_first;
    logic scan_step;
  } load_ctl_t;

endpackage

FILE: rtl/core/crlb_ram.sv
module crlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/crlb_age.sv
module crlb_age (
  input  logic [crlb_pkg::TIME_W-1:0] now_i,
  input  logic [crlb_pkg::TIME_W-1:0] last_i,
  input  logic [crlb_pkg::TIME_W-1:0] limit_i,
  output logic                        older_o
);

  logic [crlb_pkg::TIME_W:0] deadline;

  // 33-bit sum, never wraps
  assign deadline = {1'b0, last_i} + {1'b0, limit_i};
  assign older_o  = {1'b0, now_i} > deadline;

endmodule

FILE: rtl/core/crlb_load.sv
module crlb_load #(
  parameter int CORES  = 12,
  parameter int LOAD_W = 9
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  crlb_pkg::load_ctl_t                        ctl_i,
  input  logic [CORES-1:0]                           amask_i,
  input  logic [crlb_pkg::WEIGHT_W-1:0]              weight_i,
  input  logic [$clog2(CORES+1)-1:0]                 ncores_i,
  input  logic [crlb_pkg::MARGIN_W-1:0]              floor_i,
  input  logic [crlb_pkg::MARGIN_W-1:0]              margin_i,
  output logic                                       scan_done_o,
  output logic                                       move_ok_o,
  output logic [((CORES > 1) ? $clog2(CORES) : 1)-1:0] lo_idx_o,
  output logic [((CORES > 1) ? $clog2(CORES) : 1)-1:0] hi_idx_o
);

  localparam int NC_W   = $clog2(CORES + 1);
  localparam int CIDX_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int CMP_W  = (LOAD_W > crlb_pkg::MARGIN_W) ? LOAD_W : crlb_pkg::MARGIN_W;

  logic [LOAD_W-1:0] load_q [CORES];
  logic [NC_W-1:0]   idx_q;
  logic [CIDX_W-1:0] lo_q, hi_q;
  logic [LOAD_W-1:0] lo_load_q, hi_load_q;
  logic [LOAD_W-1:0] cur;
  logic [LOAD_W-1:0] spread;

  assign cur         = load_q[idx_q[CIDX_W-1:0]];
  assign scan_done_o = idx_q >= ncores_i;

  // Per-core weight accumulators
  always_ff @(posedge clk_i) begin
    for (int n = 0; n < CORES; n++) begin
      if (ctl_i.clr) begin
        load_q[n] <= '0;
      end else if (ctl_i.add && amask_i[n]) begin
        load_q[n] <= load_q[n] + LOAD_W'(weight_i);
      end
    end
  end

  // Serial min/max walk, one core a cycle, first extreme wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctl_i.scan_first) begin
      idx_q <= NC_W'(1);
    end else if (ctl_i.scan_step && !scan_done_o) begin
      idx_q <= idx_q + NC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan_first) begin
      lo_q      <= '0;
      hi_q      <= '0;
      lo_load_q <= load_q[0];
      hi_load_q <= load_q[0];
    end else if (ctl_i.scan_step && !scan_done_o) begin
      if (cur < lo_load_q) begin
        lo_q      <= idx_q[CIDX_W-1:0];
        lo_load_q <= cur;
      end
      if (cur > hi_load_q) begin
        hi_q      <= idx_q[CIDX_W-1:0];
        hi_load_q <= cur;
      end
    end
  end

  // Move threshold on the extremes
  assign spread    = hi_load_q - lo_load_q;
  assign move_ok_o = (CMP_W'(hi_load_q) >= CMP_W'(floor_i)) &&
                     (CMP_W'(spread) > CMP_W'(margin_i));
  assign lo_idx_o  = lo_q;
  assign hi_idx_o  = hi_q;

endmodule

FILE: rtl/core/core_load_rebalancer_core.sv
// Client load rebalancer.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one word per item:
// a report writes a client slot, a release clears it, a balance runs a pass
// over the slot table and returns one result word. Report and release give no
// result. Output channel (out_valid_o / out_stall_i / out_data_o) carries the
// balance result. Registers are written over cfg_valid_i / cfg_ready_o with
// cfg_index_i selecting the register; only write them while the block is idle.
// A report or release leaves the input free for the next word. A balance holds
// the input for its whole pass: the slot table sits in a single-port RAM, and
// the shared time comparator checks each slot twice (dead check, then busy
// check), followed by a min/max walk over the participating cores and a pass
// over the slots to pick the client. A disabled, busy or unsettled balance
// skips walk and pick. The result word shows up at the same edge that frees
// the input.
// The result waits in an output register; while it is stalled the block keeps
// taking items, and a later balance holds in its final step until the output
// register is free.
// Reset clears all slot valid bits and loads the register defaults; the block
// is ready as soon as reset is released.
module core_load_rebalancer_core #(
  parameter int SLOTS = 24,
  parameter int CORES = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  crlb_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output crlb_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [crlb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [crlb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IW     = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int BITS_W = $clog2(SLOTS * CORES + 1);
  localparam int NC_W   = $clog2(CORES + 1);
  localparam int CIDX_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int LOAD_W = $clog2(SLOTS * crlb_pkg::WEIGHT_MAX + 1);
  localparam int REC_W  = $bits(crlb_pkg::slot_rec_t);

  crlb_pkg::state_e state_q, state_d;

  // Config registers
  logic [crlb_pkg::CORE_W-1:0]   core_count_q;
  logic [crlb_pkg::TIME_W-1:0]   busy_tmo_q;
  logic [crlb_pkg::TIME_W-1:0]   dead_tmo_q;
  logic                          auto_q;
  logic [crlb_pkg::MARGIN_W-1:0] floor_q;
  logic [crlb_pkg::MARGIN_W-1:0] margin_q;

  // Balance working state
  logic [SLOTS-1:0]               valid_q, valid_d;
  logic [IW-1:0]                  idx_q, idx_d, nxt_idx;
  logic [crlb_pkg::TIME_W-1:0]    now_q, now_d;
  logic [crlb_pkg::REMOVED_W-1:0] removed_q, removed_d;
  logic                           busy_q, busy_d;
  logic [CNT_W-1:0]               clients_q, clients_d;
  logic [BITS_W-1:0]              bits_q, bits_d;
  logic [IW-1:0]                  pick_q, pick_d;
  logic [crlb_pkg::WEIGHT_W-1:0]  best_q, best_d;
  logic                           found_q, found_d;
  crlb_pkg::status_e              res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  crlb_pkg::out_item_t            out_q, out_d;
  logic                           last;
  logic                           in_range;

  // Slot table RAM
  logic                  ram_we;
  logic [IW-1:0]         ram_addr;
  crlb_pkg::slot_rec_t   ram_wdata;
  logic [REC_W-1:0]      ram_rdata;
  crlb_pkg::slot_rec_t   rec;

  // Shared time compare
  logic [crlb_pkg::TIME_W-1:0] age_limit;
  logic                        older;

  // Per-slot mask decode
  logic [NC_W-1:0]               ncores;
  logic [CORES-1:0]              amask;
  logic [31:0]                   aff_ext;
  logic [NC_W-1:0]               pop;
  logic [CIDX_W-1:0]             top_core;
  logic                          top_any;
  logic [crlb_pkg::WEIGHT_W-1:0] weight;

  // Load unit
  crlb_pkg::load_ctl_t ctl;
  logic                scan_done, move_ok;
  logic [CIDX_W-1:0]   lo_idx, hi_idx;

  crlb_ram #(
    .WIDTH(REC_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign rec = crlb_pkg::slot_rec_t'(ram_rdata);

  assign age_limit = (state_q == crlb_pkg::SQ_DEAD) ? dead_tmo_q : busy_tmo_q;

  crlb_age u_age (
    .now_i  (now_q),
    .last_i (rec.last_report),
    .limit_i(age_limit),
    .older_o(older)
  );

  crlb_load #(
    .CORES (CORES),
    .LOAD_W(LOAD_W)
  ) u_load (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .amask_i    (amask),
    .weight_i   (weight),
    .ncores_i   (ncores),
    .floor_i    (floor_q),
    .margin_i   (margin_q),
    .scan_done_o(scan_done),
    .move_ok_o  (move_ok),
    .lo_idx_o   (lo_idx),
    .hi_idx_o   (hi_idx)
  );

  // Participating cores and mask decode of the slot being read
  assign ncores  = (32'(core_count_q) > CORES) ? NC_W'(CORES) : NC_W'(core_count_q);
  assign aff_ext = 32'(rec.affinity);
  assign weight  = crlb_pkg::WEIGHT_BASE + crlb_pkg::WEIGHT_W'(rec.foreground)
                 + crlb_pkg::WEIGHT_W'(rec.priority_req);

  always_comb begin
    amask    = '0;
    pop      = '0;
    top_core = '0;
    for (int n = 0; n < CORES; n++) begin
      amask[n] = (32'(n) < 32'(ncores)) && aff_ext[n];
      pop      = pop + NC_W'(amask[n]);
      if (amask[n]) begin
        top_core = CIDX_W'(n);
      end
    end
  end

  assign top_any = |amask;

  assign last     = idx_q == IW'(SLOTS - 1);
  assign nxt_idx  = last ? '0 : idx_q + IW'(1);
  assign in_range = 32'(in_data_i.slot) < SLOTS;

  assign ram_wdata.affinity     = in_data_i.affinity;
  assign ram_wdata.foreground   = in_data_i.foreground;
  assign ram_wdata.priority_req = in_data_i.priority_req;
  assign ram_wdata.last_report  = in_data_i.time_ms;

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    idx_d       = idx_q;
    now_d       = now_q;
    removed_d   = removed_q;
    busy_d      = busy_q;
    clients_d   = clients_q;
    bits_d      = bits_q;
    pick_d      = pick_q;
    best_d      = best_q;
    found_d     = found_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ctl         = '0;
    ram_we      = 1'b0;
    ram_addr    = idx_q;

    // Output word taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      crlb_pkg::SQ_IDLE: begin
        ram_addr = IW'(in_data_i.slot);
        if (in_valid_i) begin
          case (in_data_i.kind)
            crlb_pkg::KIND_REPORT: begin
              if (in_range) begin
                ram_we = 1'b1;
                valid_d[IW'(in_data_i.slot)] = 1'b1;
              end
            end
            crlb_pkg::KIND_RELEASE: begin
              if (in_range) begin
                valid_d[IW'(in_data_i.slot)] = 1'b0;
              end
            end
            crlb_pkg::KIND_BALANCE: begin
              now_d     = in_data_i.time_ms;
              idx_d     = '0;
              removed_d = '0;
              busy_d    = 1'b0;
              clients_d = '0;
              bits_d    = '0;
              ctl.clr   = 1'b1;
              state_d   = crlb_pkg::SQ_PRIME;
            end
            default: ;
          endcase
        end
      end
      crlb_pkg::SQ_PRIME: begin
        state_d = crlb_pkg::SQ_DEAD;
      end
      // Clear a slot silent past the dead timeout
      crlb_pkg::SQ_DEAD: begin
        if (valid_q[idx_q] && older) begin
          valid_d[idx_q] = 1'b0;
          for (int r = 0; r < crlb_pkg::REMOVED_W; r++) begin
            if (32'(idx_q) == r) begin
              removed_d[r] = 1'b1;
            end
          end
        end
        state_d = crlb_pkg::SQ_BUSY;
      end
      // Busy check and load accumulation; prefetch next slot
      crlb_pkg::SQ_BUSY: begin
        ram_addr = nxt_idx;
        if (valid_q[idx_q]) begin
          if (older) begin
            busy_d = 1'b1;
          end
          clients_d = clients_q + CNT_W'(1);
          bits_d    = bits_q + BITS_W'(pop);
          ctl.add   = 1'b1;
        end
        idx_d   = nxt_idx;
        state_d = last ? crlb_pkg::SQ_CHECK : crlb_pkg::SQ_DEAD;
      end
      // Abort checks in priority order
      crlb_pkg::SQ_CHECK: begin
        if (!auto_q) begin
          res_d   = crlb_pkg::ST_DISABLED;
          state_d = crlb_pkg::SQ_DONE;
        end else if (busy_q) begin
          res_d   = crlb_pkg::ST_BUSY;
          state_d = crlb_pkg::SQ_DONE;
        end else if (BITS_W'(clients_q) != bits_q) begin
          res_d   = crlb_pkg::ST_UNSETTLED;
          state_d = crlb_pkg::SQ_DONE;
        end else begin
          ctl.scan_first = 1'b1;
          state_d        = crlb_pkg::SQ_SCAN;
        end
      end
      crlb_pkg::SQ_SCAN: begin
        if (scan_done) begin
          if (move_ok) begin
            state_d = crlb_pkg::SQ_PICK_PRIME;
          end else begin
            res_d   = crlb_pkg::ST_NO_MOVE;
            state_d = crlb_pkg::SQ_DONE;
          end
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      crlb_pkg::SQ_PICK_PRIME: begin
        found_d = 1'b0;
        state_d = crlb_pkg::SQ_PICK;
      end
      // First lowest-weight client sitting on the busiest core
      crlb_pkg::SQ_PICK: begin
        ram_addr = nxt_idx;
        if (valid_q[idx_q] && top_any && (top_core == hi_idx) &&
            (!found_q || (weight < best_q))) begin
          pick_d  = idx_q;
          best_d  = weight;
          found_d = 1'b1;
        end
        idx_d = nxt_idx;
        if (last) begin
          res_d   = found_d ? crlb_pkg::ST_MOVE : crlb_pkg::ST_NO_MOVE;
          state_d = crlb_pkg::SQ_DONE;
        end
      end
      crlb_pkg::SQ_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.status        = res_q;
          out_d.client_slot   = (res_q == crlb_pkg::ST_MOVE) ?
                                crlb_pkg::SLOT_W'(pick_q) : '0;
          out_d.target_core   = (res_q == crlb_pkg::ST_MOVE) ?
                                crlb_pkg::CORE_W'(lo_idx) : '0;
          out_d.removed_slots = removed_q;
          state_d             = crlb_pkg::SQ_IDLE;
        end
      end
      default: begin
        state_d = crlb_pkg::SQ_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crlb_pkg::SQ_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    now_q     <= now_d;
    removed_q <= removed_d;
    busy_q    <= busy_d;
    clients_q <= clients_d;
    bits_q    <= bits_d;
    pick_q    <= pick_d;
    best_q    <= best_d;
    found_q   <= found_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Register file writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_count_q <= crlb_pkg::CORE_COUNT_RST;
      busy_tmo_q   <= crlb_pkg::BUSY_TIMEOUT_RST;
      dead_tmo_q   <= crlb_pkg::DEAD_TIMEOUT_RST;
      auto_q       <= crlb_pkg::AUTO_BALANCE_RST;
      floor_q      <= crlb_pkg::MOVE_FLOOR_RST;
      margin_q     <= crlb_pkg::MOVE_MARGIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        crlb_pkg::CFG_CORE_COUNT:   core_count_q <= cfg_data_i[crlb_pkg::CORE_W-1:0];
        crlb_pkg::CFG_BUSY_TIMEOUT: busy_tmo_q   <= cfg_data_i[crlb_pkg::TIME_W-1:0];
        crlb_pkg::CFG_DEAD_TIMEOUT: dead_tmo_q   <= cfg_data_i[crlb_pkg::TIME_W-1:0];
        crlb_pkg::CFG_AUTO_BALANCE: auto_q       <= cfg_data_i[0];
        crlb_pkg::CFG_MOVE_FLOOR:   floor_q      <= cfg_data_i[crlb_pkg::MARGIN_W-1:0];
        crlb_pkg::CFG_MOVE_MARGIN:  margin_q     <= cfg_data_i[crlb_pkg::MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != crlb_pkg::SQ_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/crlb_checker.sv
module crlb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input crlb_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input crlb_pkg::out_item_t out_data_o
);

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // Slot and core are zero unless a move is requested
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != crlb_pkg::ST_MOVE) |->
      (out_data_o.client_slot == '0) && (out_data_o.target_core == '0))
    else $error("slot or core set without a move");

  // A balance word starts a multi-cycle pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.kind == crlb_pkg::KIND_BALANCE) |=> in_stall_o)
    else $error("input not stalled after balance word");

  // Table updates leave the input free for the next word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && ((in_data_i.kind == crlb_pkg::KIND_REPORT) ||
      (in_data_i.kind == crlb_pkg::KIND_RELEASE)) |=> !in_stall_o)
    else $error("input stalled after report or release");

  // A new result only comes out of a balance pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a balance pass");

endmodule

bind core_load_rebalancer_core crlb_checker u_crlb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import crlb_pkg::*;

  localparam int SLOTS = 24;
  localparam int CORES = 12;
  localparam int SETTLE_CYCLES = 128;
  localparam int ITEM_GOAL = 1750;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  // One row of the directed plan: a register write or an input word
  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              word;
    bit                    typed;
    out_item_t             want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow of the client table and registers
  logic                  tbl_valid [SLOTS];
  logic [AFF_W-1:0]      tbl_aff   [SLOTS];
  logic [TIME_W-1:0]     tbl_last  [SLOTS];
  logic                  tbl_fg    [SLOTS];
  logic                  tbl_pr    [SLOTS];
  logic [CORE_W-1:0]     cfg_cores;
  logic [TIME_W-1:0]     cfg_busy;
  logic [TIME_W-1:0]     cfg_dead;
  logic                  cfg_auto;
  logic [MARGIN_W-1:0]   cfg_floor;
  logic [MARGIN_W-1:0]   cfg_margin;

  out_item_t             pending_results [$];
  plan_row_t             plan_rows [$];
  int                    fail_count = 0;
  int                    items_done = 0;
  int                    burst_left = 0;
  logic [TIME_W-1:0]     clock_ms = '0;
  stall_mode_e           stall_mode = STALL_NONE;
  int                    stall_left = 0;

  core_load_rebalancer_core #(
    .SLOTS(SLOTS),
    .CORES(CORES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // 33-bit compare so that last + limit never wraps
  function automatic bit stale(logic [TIME_W-1:0] now, logic [TIME_W-1:0] last,
                               logic [TIME_W-1:0] limit);
    return {1'b0, now} > ({1'b0, last} + {1'b0, limit});
  endfunction

  function automatic int active_cores();
    return (cfg_cores > CORES) ? CORES : int'(cfg_cores);
  endfunction

  function automatic int weight_of(int s);
    return int'(WEIGHT_BASE) + tbl_fg[s] + tbl_pr[s];
  endfunction

  function automatic void clear_entry(int s);
    tbl_valid[s] = 1'b0;
    tbl_aff[s]   = '0;
    tbl_last[s]  = '0;
    tbl_fg[s]    = 1'b0;
    tbl_pr[s]    = 1'b0;
  endfunction

  function automatic void reset_shadow();
    cfg_cores  = CORE_COUNT_RST;
    cfg_busy   = BUSY_TIMEOUT_RST;
    cfg_dead   = DEAD_TIMEOUT_RST;
    cfg_auto   = AUTO_BALANCE_RST;
    cfg_floor  = MOVE_FLOOR_RST;
    cfg_margin = MOVE_MARGIN_RST;
    for (int s = 0; s < SLOTS; s++) clear_entry(s);
  endfunction

  // Update the table for one accepted word; a balance queues its result
  task automatic apply_item(input in_item_t w, input bit typed, input out_item_t want);
    out_item_t   res;
    int unsigned load [CORES];
    int          on_core [SLOTS];
    int          s, n, nc, clients, bits, lo, hi, pick, best, wt;
    bit          halted;
    if (w.kind == KIND_REPORT || w.kind == KIND_RELEASE) begin
      if (w.slot < SLOTS) begin
        if (w.kind == KIND_REPORT) begin
          tbl_valid[w.slot] = 1'b1;
          tbl_aff[w.slot]   = w.affinity;
          tbl_fg[w.slot]    = w.foreground;
          tbl_pr[w.slot]    = w.priority_req;
          tbl_last[w.slot]  = w.time_ms;
        end else begin
          clear_entry(w.slot);
        end
      end
      return;
    end
    if (w.kind != KIND_BALANCE) return;

    res = '0;
    res.status = ST_NO_MOVE;
    // dead slots go first, whatever follows
    for (s = 0; s < SLOTS; s++) begin
      if (tbl_valid[s] && stale(w.time_ms, tbl_last[s], cfg_dead)) begin
        clear_entry(s);
        res.removed_slots[s] = 1'b1;
      end
    end

    halted = 1'b0;
    if (!cfg_auto) begin
      res.status = ST_DISABLED;
      halted = 1'b1;
    end

    // per-core loads; a client sits on its highest participating core
    nc = active_cores();
    clients = 0;
    bits = 0;
    for (n = 0; n < CORES; n++) load[n] = 0;
    for (s = 0; s < SLOTS && !halted; s++) begin
      on_core[s] = -1;
      if (tbl_valid[s]) begin
        if (stale(w.time_ms, tbl_last[s], cfg_busy)) begin
          res.status = ST_BUSY;
          halted = 1'b1;
        end else begin
          clients++;
          for (n = 0; n < nc; n++) begin
            if (tbl_aff[s][n]) begin
              load[n] += weight_of(s);
              on_core[s] = n;
              bits++;
            end
          end
        end
      end
    end
    if (!halted && clients != bits) begin
      res.status = ST_UNSETTLED;
      halted = 1'b1;
    end

    if (!halted) begin
      lo = 0;
      hi = 0;
      for (n = 1; n < nc; n++) begin
        if (load[lo] > load[n]) lo = n;
        if (load[hi] < load[n]) hi = n;
      end
      pick = -1;
      best = 0;
      if (load[hi] >= cfg_floor && load[hi] - load[lo] > cfg_margin) begin
        for (s = 0; s < SLOTS; s++) begin
          if (on_core[s] == hi) begin
            wt = weight_of(s);
            if (pick < 0 || wt < best) begin
              pick = s;
              best = wt;
            end
          end
        end
      end
      if (pick >= 0) begin
        res.status = ST_MOVE;
        res.client_slot = SLOT_W'(pick);
        res.target_core = CORE_W'(lo);
      end
    end
    pending_results.push_back(typed ? want : res);
  endtask

  // ------------------------------------------------------------------ drivers

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input in_item_t w, input bit typed, input out_item_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid_i = 1'b1;
    in_data_i  = w;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(w, typed, want);
    if (w.kind == KIND_BALANCE || (w.kind != KIND_UNUSED && w.slot < SLOTS)) items_done++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Register writes only with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CORE_COUNT:   cfg_cores  = val[CORE_W-1:0];
      CFG_BUSY_TIMEOUT: cfg_busy   = val[TIME_W-1:0];
      CFG_DEAD_TIMEOUT: cfg_dead   = val[TIME_W-1:0];
      CFG_AUTO_BALANCE: cfg_auto   = val[0];
      CFG_MOVE_FLOOR:   cfg_floor  = val[MARGIN_W-1:0];
      CFG_MOVE_MARGIN:  cfg_margin = val[MARGIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // --------------------------------------------------------------- stimulus

  function automatic in_item_t item_of(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                                       logic [AFF_W-1:0] aff, logic fg, logic pr,
                                       logic [TIME_W-1:0] t);
    in_item_t w;
    w.kind = k;
    w.slot = s;
    w.affinity = aff;
    w.foreground = fg;
    w.priority_req = pr;
    w.time_ms = t;
    return w;
  endfunction

  function automatic in_item_t rand_item(logic [KIND_W-1:0] k);
    return item_of(k, SLOT_W'($urandom), AFF_W'($urandom), 1'($urandom), 1'($urandom),
                   $urandom);
  endfunction

  // A settled client: one participating bit, mostly on the hot core
  function automatic in_item_t client_report(int s, int nc, int hot);
    in_item_t w;
    int       core_n;
    w = rand_item(KIND_REPORT);
    w.slot = SLOT_W'(s);
    core_n = ($urandom_range(0, 9) < 6) ? hot : $urandom_range(0, nc - 1);
    w.affinity = AFF_W'(1) << core_n;
    // bits above the participating cores do not count
    if (nc < AFF_W && $urandom_range(0, 4) == 0)
      w.affinity |= AFF_W'($urandom) & ~((AFF_W'(1) << nc) - AFF_W'(1));
    w.time_ms = clock_ms;
    return w;
  endfunction

  function automatic logic [31:0] pick_reg(logic [31:0] lo_v, logic [31:0] hi_v);
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(hi_v, lo_v);
    endcase
  endfunction

  task automatic plan_item(input in_item_t w);
    plan_rows.push_back('{is_reg: 1'b0, reg_idx: '0, reg_val: '0, word: w, typed: 1'b0,
                          want: '0});
  endtask

  task automatic plan_check(input in_item_t w, input out_item_t want);
    plan_rows.push_back('{is_reg: 1'b0, reg_idx: '0, reg_val: '0, word: w, typed: 1'b1,
                          want: want});
  endtask

  task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    plan_rows.push_back('{is_reg: 1'b1, reg_idx: idx, reg_val: val, word: '0, typed: 1'b0,
                          want: '0});
  endtask

  task automatic build_plan();
    // empty table under reset values
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 0), '{ST_NO_MOVE, 5'd0, 4'd0, 24'd0});
    // unknown kind and slots past the table are dropped
    plan_item(item_of(KIND_UNUSED, 31, 12'hFFF, 1, 1, 32'hFFFF_FFFF));
    plan_item(item_of(KIND_REPORT, 31, 12'hFFF, 1, 1, 5));
    plan_item(item_of(KIND_RELEASE, 24, 12'h000, 0, 0, 5));
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 1), '{ST_NO_MOVE, 5'd0, 4'd0, 24'd0});
    // dead slot cleared even when balancing is off
    plan_reg(CFG_AUTO_BALANCE, 0);
    plan_item(item_of(KIND_REPORT, 5, 12'h001, 0, 0, 10));
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 100000),
               '{ST_DISABLED, 5'd0, 4'd0, 24'h000020});
    plan_reg(CFG_AUTO_BALANCE, 1);
    plan_reg(CFG_CORE_COUNT, 3);
    // three clients piled on core 0, the lightest moves to core 1
    plan_item(item_of(KIND_REPORT, 0, 12'h001, 1, 1, 100));
    plan_item(item_of(KIND_REPORT, 1, 12'h001, 0, 0, 100));
    plan_item(item_of(KIND_REPORT, 2, 12'h001, 0, 1, 100));
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 200), '{ST_MOVE, 5'd1, 4'd1, 24'd0});
    // two mask bits on one client: unsettled, but busy wins over it
    plan_item(item_of(KIND_REPORT, 3, 12'h006, 0, 0, 200));
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 300), '{ST_UNSETTLED, 5'd0, 4'd0, 24'd0});
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 3101), '{ST_BUSY, 5'd0, 4'd0, 24'd0});
    plan_item(item_of(KIND_RELEASE, 3, 12'h000, 0, 0, 0));
    // mask bits above core_count are not counted
    plan_item(item_of(KIND_REPORT, 4, 12'hF04, 1, 1, 3000));
    plan_item(item_of(KIND_BALANCE, 0, 0, 0, 0, 3100));
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 200000),
               '{ST_NO_MOVE, 5'd0, 4'd0, 24'h000017});
    // top slot and top core, times at the end of the range
    plan_reg(CFG_CORE_COUNT, 15);
    plan_item(item_of(KIND_REPORT, 23, 12'h800, 0, 0, 32'hFFFF_FFFF));
    plan_item(item_of(KIND_REPORT, 22, 12'h800, 1, 0, 32'hFFFF_FF00));
    plan_item(item_of(KIND_BALANCE, 0, 0, 0, 0, 32'hFFFF_FFFF));
    plan_item(item_of(KIND_BALANCE, 0, 0, 0, 0, 0));
    plan_reg(CFG_MOVE_FLOOR, 255);
    plan_reg(CFG_MOVE_MARGIN, 255);
    plan_reg(CFG_BUSY_TIMEOUT, 32'hFFFF_FFFF);
    plan_reg(CFG_DEAD_TIMEOUT, 0);
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 32'hFFFF_FFFF),
               '{ST_NO_MOVE, 5'd0, 4'd0, 24'h400000});
    // no cores taking part
    plan_reg(CFG_MOVE_FLOOR, 0);
    plan_reg(CFG_MOVE_MARGIN, 0);
    plan_reg(CFG_CORE_COUNT, 0);
    plan_item(item_of(KIND_BALANCE, 0, 0, 0, 0, 32'hFFFF_FFFF));
    plan_item(item_of(KIND_RELEASE, 23, 12'h000, 0, 0, 0));
    plan_check(item_of(KIND_BALANCE, 0, 0, 0, 0, 32'hFFFF_FFFF),
               '{ST_NO_MOVE, 5'd0, 4'd0, 24'd0});
  endtask

  // Refresh or drop the clients on file, add a few, then balance
  task automatic run_episode();
    in_item_t w;
    int       s, nc, hot, lim;
    nc = active_cores();
    hot = (nc > 0) ? $urandom_range(0, nc - 1) : 0;
    for (s = 0; s < SLOTS; s++) begin
      if (tbl_valid[s]) begin
        if (nc == 0 || $urandom_range(0, 3) == 0) begin
          w = rand_item(KIND_RELEASE);
          w.slot = SLOT_W'(s);
          send_word(w, 1'b0, '0);
        end else begin
          send_word(client_report(s, nc, hot), 1'b0, '0);
        end
      end
    end
    if (nc > 0)
      repeat ($urandom_range(0, 6))
        send_word(client_report($urandom_range(0, SLOTS - 1), nc, hot), 1'b0, '0);
    lim = (cfg_busy > 32'd4000) ? 500 : int'(cfg_busy) / 8;
    repeat ($urandom_range(1, 3)) begin
      clock_ms += TIME_W'($urandom_range(0, lim));
      w = rand_item(KIND_BALANCE);
      w.time_ms = clock_ms;
      send_word(w, 1'b0, '0);
    end
  endtask

  // Broken or odd words: unknown kind, stray slots, loose masks, time jumps
  task automatic run_noise();
    in_item_t w;
    case ($urandom_range(0, 4))
      0: w = rand_item(KIND_UNUSED);
      1: w = rand_item($urandom_range(0, 1) ? KIND_REPORT : KIND_RELEASE);
      2: begin
        clock_ms += $urandom_range(0, 1) ? $urandom : cfg_busy + TIME_W'($urandom_range(0, 2));
        w = rand_item(KIND_BALANCE);
        w.time_ms = clock_ms;
      end
      3: w = rand_item(KIND_BALANCE);
      default: begin
        w = rand_item(KIND_REPORT);
        w.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
        w.time_ms = clock_ms;
      end
    endcase
    send_word(w, 1'b0, '0);
  endtask

  task automatic run_phase();
    int target;
    case ($urandom_range(0, 5))
      0: write_reg(CFG_CORE_COUNT, 0);
      1: write_reg(CFG_CORE_COUNT, 15);
      2: write_reg(CFG_CORE_COUNT, CORES);
      3: write_reg(CFG_CORE_COUNT, $urandom_range(0, 15));
      default: write_reg(CFG_CORE_COUNT, $urandom_range(1, CORES));
    endcase
    write_reg(CFG_BUSY_TIMEOUT, pick_reg(200, 5000));
    write_reg(CFG_DEAD_TIMEOUT, pick_reg(2000, 100000));
    write_reg(CFG_AUTO_BALANCE, ($urandom_range(0, 9) != 0));
    write_reg(CFG_MOVE_FLOOR, MARGIN_W'(pick_reg(0, 60)));
    write_reg(CFG_MOVE_MARGIN, MARGIN_W'(pick_reg(0, 30)));
    clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
    target = items_done + $urandom_range(60, 160);
    while (items_done < target) begin
      run_episode();
      repeat ($urandom_range(0, 2)) run_noise();
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  initial begin
    reset_shadow();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    build_plan();
    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_reg) write_reg(plan_rows[i].reg_idx, plan_rows[i].reg_val);
      else send_word(plan_rows[i].word, plan_rows[i].typed, plan_rows[i].want);
    end

    while (items_done < ITEM_GOAL) run_phase();

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ----------------------------------------------------------------- receiver

  // Output stall pattern: runs of no stall, light, heavy and toggling stall
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 120);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i = 1'b0;
      STALL_LIGHT: out_stall_i = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i = ($urandom_range(0, 3) != 0);
      default:     out_stall_i = ~out_stall_i;
    endcase
  end

  task automatic cmp_field(input string label, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      fail_count++;
    end
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_data_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        cmp_field("status", exp_r.status, out_data_o.status);
        cmp_field("client_slot", exp_r.client_slot, out_data_o.client_slot);
        cmp_field("target_core", exp_r.target_core, out_data_o.target_core);
        cmp_field("removed_slots", exp_r.removed_slots, out_data_o.removed_slots);
      end
    end
  end

endmodule
